[hw/rtl/differential_drive_wheel_mixer_assert.svh]
// ----------------------------------------------------------------------------
// differential_drive_wheel_mixer_assert.svh
// assertion macros for the wheel mixer, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_WHEEL_MIXER_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_WHEEL_MIXER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DDWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ddwm assertion failed");

// next-cycle implication
`define DDWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ddwm assertion failed");

`else

`define DDWM_ASSERT_NOW(label, ante, cons)
`define DDWM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hw/rtl/ddwm_pkg.sv]
// ----------------------------------------------------------------------------
// ddwm_pkg
// constants, types and tables shared by the wheel mixer files
// ----------------------------------------------------------------------------
package ddwm_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int VEL_W      = 16;
  localparam int SPEED_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int CW          = 27;
  localparam int SQ_W        = 32;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int SQRT_STEPS  = SQ_W / 2;
  localparam int ITER_STAGES = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

  localparam int C_W     = 23;
  localparam int P1_W    = ANGLE_BITS + GAIN_W;
  localparam int P2_W    = P1_W + C_W;
  localparam int Q_SHIFT = ANGLE_BITS + 20;
  localparam int Q_W     = P2_W - Q_SHIFT;
  localparam int MIX_W   = VEL_W + 2;

  localparam logic [C_W-1:0] TWO_PI_Q20 = C_W'(6588397);
  localparam logic [SQ_W-1:0] SQ_TOP_BIT = SQ_W'(1) << (SQ_W - 2);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN = CFG_IDX_W'(1);

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = SPEED_W'(256);
  localparam logic [GAIN_W-1:0]  STEER_GAIN_RST = GAIN_W'(256);

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [CW-1:0]  cval_t;

  localparam angle_t HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  localparam int TABLE_LEN = 24;
  localparam logic [31:0] ATAN_TAB32 [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // per-iteration rotation angle, rounded to the angle width
  function automatic angle_t atan_step(input int idx);
    logic [32:0] s;
    s = {1'b0, ATAN_TAB32[idx]} + (33'(1) << (31 - ANGLE_BITS));
    return s[32 - ANGLE_BITS +: ANGLE_BITS];
  endfunction

  // 16-bit binary angle to the internal angle width
  function automatic angle_t head_angle(input logic [VEL_W-1:0] hd);
    logic [VEL_W+ANGLE_BITS-1:0] w;
    w = {hd, {ANGLE_BITS{1'b0}}};
    return w[VEL_W+ANGLE_BITS-1 -: ANGLE_BITS];
  endfunction

  typedef struct packed {
    cval_t             x;
    cval_t             y;
    angle_t            z;
    logic              zero;
    logic [SQ_W-1:0]   rem;
    logic [SQ_W-1:0]   root;
    angle_t            head;
    logic              goal;
  } iter_t;

  typedef struct packed {
    angle_t          z;
    logic            zero;
    angle_t          head;
    logic            goal;
    logic [SQ_W-1:0] root;
  } vec_res_t;

endpackage

[hw/rtl/ddwm_ifs.sv]
// ----------------------------------------------------------------------------
// ddwm_ifs
// valid/ready channels of the wheel mixer: command, speed and config words
// ----------------------------------------------------------------------------
interface ddwm_cmd_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddwm_pkg::VEL_W-1:0]  new_vel_x;
  logic signed [ddwm_pkg::VEL_W-1:0]  new_vel_y;
  logic [ddwm_pkg::VEL_W-1:0]         heading;
  logic                               goal_reached;

  modport source (output valid, new_vel_x, new_vel_y, heading, goal_reached, input ready);
  modport sink (input valid, new_vel_x, new_vel_y, heading, goal_reached, output ready);
endinterface

interface ddwm_speed_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddwm_pkg::VEL_W-1:0]  left_speed;
  logic signed [ddwm_pkg::VEL_W-1:0]  right_speed;

  modport source (output valid, left_speed, right_speed, input ready);
  modport sink (input valid, left_speed, right_speed, output ready);
endinterface

interface ddwm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ddwm_pkg::CFG_IDX_W-1:0]      index;
  logic [ddwm_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/differential_drive_wheel_mixer.sv]
// ----------------------------------------------------------------------------
// differential_drive_wheel_mixer
// velocity vector and heading in, left and right wheel speeds out
//
//   channel  dir  word
//   cmd      in   new_vel_x, new_vel_y, heading, goal_reached
//   speed    out  left_speed, right_speed
//   cfg      in   index (0 max_speed, 1 steer_gain), data
//
// one word per cycle sustained while speed is not stalled, through the unrolled
// cordic and square root stages
// synchronous reset clears valid bits and loads register defaults
// a stall on speed freezes the whole pipeline, cmd.ready drops with it
// cfg is always ready and takes effect on the next cycle
// ----------------------------------------------------------------------------
`include "differential_drive_wheel_mixer_assert.svh"

module differential_drive_wheel_mixer (
  input  logic         clk,
  input  logic         rst,
  ddwm_cmd_if.sink     cmd,
  ddwm_speed_if.source speed,
  ddwm_cfg_if.sink     cfg
);

  localparam int VW = ddwm_pkg::VEL_W;
  localparam int MW = ddwm_pkg::MIX_W;

  logic en;

  logic [ddwm_pkg::SPEED_W-1:0] max_speed;
  logic [ddwm_pkg::GAIN_W-1:0]  steer_gain;

  logic               vec_vld;
  ddwm_pkg::vec_res_t vec_res;

  ddwm_pkg::angle_t target;
  ddwm_pkg::angle_t diff;
  logic             diff_neg;

  logic                      e_vld;
  ddwm_pkg::angle_t          e_mag;
  logic                      e_neg;
  logic [ddwm_pkg::ROOT_W-1:0] e_t;

  logic                      m1_vld;
  logic [ddwm_pkg::P1_W-1:0] m1_p1;
  logic                      m1_neg;
  logic [ddwm_pkg::ROOT_W-1:0] m1_t;

  logic                      m2_vld;
  logic [ddwm_pkg::P2_W-1:0] m2_p2;
  logic                      m2_neg;
  logic [ddwm_pkg::ROOT_W-1:0] m2_t;

  logic [ddwm_pkg::P2_W-1:0] rnd_sum;
  logic [ddwm_pkg::Q_W-1:0]  q_raw;
  logic [VW-1:0]             lim;

  logic                      r_vld;
  logic [VW-1:0]             r_q;
  logic                      r_neg;
  logic [ddwm_pkg::ROOT_W-1:0] r_t;
  logic [VW-1:0]             r_lim;

  logic [MW-1:0] need;
  logic [MW-1:0] ms_s;
  logic [MW-1:0] q_s;
  logic [MW-1:0] t_s;
  logic [MW-1:0] h_s;
  logic [MW-1:0] left_next;
  logic [MW-1:0] right_next;

  logic          x_vld;
  logic [VW-1:0] left;
  logic [VW-1:0] right;

  assign en        = !x_vld || speed.ready;
  assign cmd.ready = en;
  assign cfg.ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed  <= ddwm_pkg::MAX_SPEED_RST;
      steer_gain <= ddwm_pkg::STEER_GAIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ddwm_pkg::CFG_MAX_SPEED:  max_speed  <= cfg.data[ddwm_pkg::SPEED_W-1:0];
        ddwm_pkg::CFG_STEER_GAIN: steer_gain <= cfg.data[ddwm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  ddwm_vector u_vector (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cmd.valid),
    .vel_x     (cmd.new_vel_x),
    .vel_y     (cmd.new_vel_y),
    .heading   (cmd.heading),
    .goal      (cmd.goal_reached),
    .out_valid (vec_vld),
    .res       (vec_res)
  );

  // heading error, half turn counts positive
  always_comb begin
    if (vec_res.goal) begin
      target = vec_res.head;
    end else if (vec_res.zero) begin
      target = '0;
    end else begin
      target = vec_res.z;
    end
    diff     = target - vec_res.head;
    diff_neg = diff > ddwm_pkg::HALF_TURN;
  end

  // rounding and clamp of the speed difference
  assign rnd_sum = m2_p2 + (ddwm_pkg::P2_W'(1) << (ddwm_pkg::Q_SHIFT - 1));
  assign q_raw   = rnd_sum[ddwm_pkg::P2_W-1:ddwm_pkg::Q_SHIFT];
  assign lim     = {max_speed, 1'b0};

  // wheel mixing
  always_comb begin
    ms_s = MW'(r_lim[VW-1:1]);
    q_s  = MW'(r_q);
    t_s  = MW'(r_t);
    h_s  = MW'((VW+1)'(r_q) + (VW+1)'(1) >> 1);
    need = {t_s[MW-2:0], 1'b0} + q_s;
    if (need > MW'(r_lim)) begin
      if (!r_neg) begin
        right_next = ms_s;
        left_next  = ms_s - q_s;
      end else begin
        left_next  = ms_s;
        right_next = ms_s - q_s;
      end
    end else begin
      if (!r_neg) begin
        right_next = t_s + h_s;
        left_next  = t_s - h_s;
      end else begin
        right_next = t_s - h_s;
        left_next  = t_s + h_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld  <= 1'b0;
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      r_vld  <= 1'b0;
      x_vld  <= 1'b0;
    end else if (en) begin
      e_vld  <= vec_vld;
      m1_vld <= e_vld;
      m2_vld <= m1_vld;
      r_vld  <= m2_vld;
      x_vld  <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_mag  <= diff_neg ? -diff : diff;
      e_neg  <= diff_neg;
      e_t    <= vec_res.root[ddwm_pkg::ROOT_W-1:0];

      m1_p1  <= ddwm_pkg::P1_W'(e_mag) * ddwm_pkg::P1_W'(steer_gain);
      m1_neg <= e_neg;
      m1_t   <= e_t;

      m2_p2  <= ddwm_pkg::P2_W'(m1_p1) * ddwm_pkg::P2_W'(ddwm_pkg::TWO_PI_Q20);
      m2_neg <= m1_neg;
      m2_t   <= m1_t;

      r_q    <= (q_raw > ddwm_pkg::Q_W'(lim)) ? lim : q_raw[VW-1:0];
      r_neg  <= m2_neg;
      r_t    <= m2_t;
      r_lim  <= lim;

      left   <= left_next[VW-1:0];
      right  <= right_next[VW-1:0];
    end
  end

  assign speed.valid       = x_vld;
  assign speed.left_speed  = left;
  assign speed.right_speed = right;

  `DDWM_ASSERT_NOW(a_err_half, e_vld, e_mag <= ddwm_pkg::HALF_TURN)
  `DDWM_ASSERT_NOW(a_root_narrow, vec_vld, vec_res.root[ddwm_pkg::SQ_W-1:ddwm_pkg::ROOT_W] == '0)
  `DDWM_ASSERT_NEXT(a_stall_hold, !en && m2_vld, $stable(m2_p2) && m2_vld)

endmodule

[hw/rtl/ddwm_vector.sv]
// ----------------------------------------------------------------------------
// ddwm_vector
// pipelined cordic vectoring (target angle) and integer square root (speed)
// ----------------------------------------------------------------------------
module ddwm_vector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [ddwm_pkg::VEL_W-1:0]  vel_x,
  input  logic signed [ddwm_pkg::VEL_W-1:0]  vel_y,
  input  logic [ddwm_pkg::VEL_W-1:0]         heading,
  input  logic                               goal,
  output logic                               out_valid,
  output ddwm_pkg::vec_res_t                 res
);

  localparam int NST = ddwm_pkg::ITER_STAGES;
  localparam int CW  = ddwm_pkg::CW;
  localparam int VW  = ddwm_pkg::VEL_W;

  logic [NST+1:0]         vld;
  ddwm_pkg::iter_t        st [NST+2];
  ddwm_pkg::iter_t        init;
  ddwm_pkg::iter_t        sum_st;
  logic [ddwm_pkg::SQ_W-1:0] sqx;
  logic [ddwm_pkg::SQ_W-1:0] sqy;
  logic signed [ddwm_pkg::SQ_W-1:0] sqx_s;
  logic signed [ddwm_pkg::SQ_W-1:0] sqy_s;
  ddwm_pkg::cval_t        x_in;
  ddwm_pkg::cval_t        y_in;

  assign x_in = {{(CW-VW-8){vel_x[VW-1]}}, vel_x, 8'd0};
  assign y_in = {{(CW-VW-8){vel_y[VW-1]}}, vel_y, 8'd0};
  assign sqx_s = ddwm_pkg::SQ_W'(vel_x) * ddwm_pkg::SQ_W'(vel_x);
  assign sqy_s = ddwm_pkg::SQ_W'(vel_y) * ddwm_pkg::SQ_W'(vel_y);

  // pre-rotation into the right half plane
  always_comb begin
    init      = '0;
    init.x    = vel_x[VW-1] ? -x_in : x_in;
    init.y    = vel_x[VW-1] ? -y_in : y_in;
    init.z    = vel_x[VW-1] ? ddwm_pkg::HALF_TURN : '0;
    init.zero = (vel_x == '0) && (vel_y == '0);
    init.head = ddwm_pkg::head_angle(heading);
    init.goal = goal;
  end

  always_comb begin
    sum_st      = st[0];
    sum_st.rem  = sqx + sqy;
    sum_st.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= init;
      sqx   <= ddwm_pkg::SQ_W'(sqx_s);
      sqy   <= ddwm_pkg::SQ_W'(sqy_s);
      st[1] <= sum_st;
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_iter
    localparam ddwm_pkg::angle_t A = (k < ddwm_pkg::CORDIC_STAGES) ?
                                     ddwm_pkg::atan_step(k) : '0;
    localparam logic [ddwm_pkg::SQ_W-1:0] SBIT = ddwm_pkg::SQ_TOP_BIT >> (2 * k);

    ddwm_pkg::iter_t        cur;
    ddwm_pkg::iter_t        nxt;
    logic                   y_pos;
    logic [ddwm_pkg::SQ_W:0] trial;

    assign cur   = st[k+1];
    assign y_pos = !cur.y[CW-1] && (cur.y != '0);
    assign trial = {1'b0, cur.root} + {1'b0, SBIT};

    always_comb begin
      nxt = cur;
      if (k < ddwm_pkg::CORDIC_STAGES) begin
        if (y_pos) begin
          nxt.x = cur.x + ($signed(cur.y) >>> k);
          nxt.y = cur.y - ($signed(cur.x) >>> k);
          nxt.z = cur.z + A;
        end else begin
          nxt.x = cur.x - ($signed(cur.y) >>> k);
          nxt.y = cur.y + ($signed(cur.x) >>> k);
          nxt.z = cur.z - A;
        end
      end
      if (k < ddwm_pkg::SQRT_STEPS) begin
        if ({1'b0, cur.rem} >= trial) begin
          nxt.rem  = cur.rem - trial[ddwm_pkg::SQ_W-1:0];
          nxt.root = (cur.root >> 1) + SBIT;
        end else begin
          nxt.root = cur.root >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+2] <= nxt;
      end
    end
  end

  assign out_valid = vld[NST+1];
  assign res.z     = st[NST+1].z;
  assign res.zero  = st[NST+1].zero;
  assign res.head  = st[NST+1].head;
  assign res.goal  = st[NST+1].goal;
  assign res.root  = st[NST+1].root;

endmodule
